/* hdl/pffd_pkg.sv */
// Shared types and constants of the packed float field decoder.
package pffd_pkg;

    localparam int Q_W      = 48;
    localparam int RAW_W    = 32;
    localparam int BITS_W   = 6;
    localparam int DEN_W    = 32;
    localparam int PROD_W   = Q_W + DEN_W;
    localparam int USED_W   = 37;
    localparam int OUT_TDATA_W = ((Q_W + RAW_W + BITS_W + 7) / 8) * 8;

    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};

    localparam logic [3:0] MODE_COORD     = 4'd0;
    localparam logic [3:0] MODE_MP        = 4'd1;
    localparam logic [3:0] MODE_MP_LOW    = 4'd2;
    localparam logic [3:0] MODE_MP_INT    = 4'd3;
    localparam logic [3:0] MODE_RAW       = 4'd4;
    localparam logic [3:0] MODE_NORMAL    = 4'd5;
    localparam logic [3:0] MODE_CELL      = 4'd6;
    localparam logic [3:0] MODE_CELL_LOW  = 4'd7;
    localparam logic [3:0] MODE_CELL_INT  = 4'd8;
    localparam logic [3:0] MODE_INTERP    = 4'd9;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_FBITS = 2'd1;
    localparam logic [1:0] REG_LOW   = 2'd2;
    localparam logic [1:0] REG_HIGH  = 2'd3;

    typedef struct packed {
        logic [Q_W-1:0]    val;
        logic [RAW_W-1:0]  raw;
        logic              is_raw;
        logic [BITS_W-1:0] bits;
        logic              interp;
    } t_side;

endpackage

/* hdl/packed_float_field_decoder.sv */
// Top level: packed float field decoder with stream ports and APB registers.
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tdata: bit window
//  m_axis    out  tvalid/tready             tdata: value, raw word, bits used; tuser: is_raw
//  apb       in   psel/penable/pwrite       paddr, pwdata -> prdata, pready
//
// One item per cycle while the skid entry is empty; the path runs through decode,
// partial products, product sum, 24 divider stages for the interpolation divide
// (two quotient bits each), and the output register.
// Synchronous active-low reset clears valid bits and registers to reset values.
// A two-entry output buffer keeps input ready high while one result waits;
// tready drops only when both entries are full.
module packed_float_field_decoder #(
    parameter int WINDOW_BITS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [WINDOW_BITS-1:0] bit_window
    input  logic [((WINDOW_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [47:0] value_fixed, [79:48] raw_word, [85:80] bits_used, [87:86] zero
    output logic [pffd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] is_raw
    output logic [0:0]                           m_axis_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [4:0]                           paddr,
    input  logic [63:0]                          pwdata,
    output logic [63:0]                          prdata,
    output logic                                 pready
);

    localparam int QW = pffd_pkg::Q_W;
    localparam int OW = pffd_pkg::OUT_TDATA_W;

    // configuration
    logic [3:0]    r_mode;
    logic [5:0]    r_fbits;
    logic [QW-1:0] r_low;
    logic [QW-1:0] r_high;
    logic [pffd_pkg::DEN_W-1:0] r_den;
    logic [QW-1:0] r_mag;
    logic          r_dneg;

    logic          w_cfg_wr;
    logic [QW:0]   n_diff;
    logic [QW:0]   n_diffn;
    logic [5:0]    n_nbits;
    logic [pffd_pkg::DEN_W-1:0] n_mask;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= pffd_pkg::MODE_INTERP;
            r_fbits <= 6'd8;
            r_low   <= '0;
            r_high  <= QW'(65536);
        end else if (w_cfg_wr) begin
            case (paddr[4:3])
                pffd_pkg::REG_MODE:  r_mode  <= pwdata[3:0];
                pffd_pkg::REG_FBITS: r_fbits <= pwdata[5:0];
                pffd_pkg::REG_LOW:   r_low   <= pwdata[QW-1:0];
                pffd_pkg::REG_HIGH:  r_high  <= pwdata[QW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            pffd_pkg::REG_MODE:  prdata = {60'd0, r_mode};
            pffd_pkg::REG_FBITS: prdata = {58'd0, r_fbits};
            pffd_pkg::REG_LOW:   prdata = {16'd0, r_low};
            pffd_pkg::REG_HIGH:  prdata = {16'd0, r_high};
            default:             prdata = '0;
        endcase
    end

    always_comb begin
        if (r_fbits == 6'd0) begin
            n_nbits = 6'd1;
        end else if (r_fbits > 6'd32) begin
            n_nbits = 6'd32;
        end else begin
            n_nbits = r_fbits;
        end
        n_mask  = pffd_pkg::DEN_W'((33'h1 << n_nbits) - 33'h1);
        n_diff  = {r_high[QW-1], r_high} - {r_low[QW-1], r_low};
        n_diffn = {r_low[QW-1], r_low} - {r_high[QW-1], r_high};
    end

    always_ff @(posedge i_clk) begin
        r_den  <= n_mask;
        r_dneg <= n_diff[QW];
        r_mag  <= n_diff[QW] ? n_diffn[QW-1:0] : n_diff[QW-1:0];
    end

    // pipeline enable
    logic r_skd_vld;
    logic w_en;
    assign w_en          = ~r_skd_vld;
    assign s_axis_tready = w_en;

    // stage 1: field decode
    logic [pffd_pkg::USED_W-1:0] w_win;
    logic [pffd_pkg::USED_W-1:0] n_csh;
    logic [15:0]   n_nt;
    logic [16:0]   n_nsum;
    logic [16:0]   n_nval;
    logic [QW:0]   n1_val;
    logic          n1_neg;
    logic [31:0]   n1_raw;
    logic          n1_is_raw;
    logic [5:0]    n1_bits;
    logic          n1_interp;
    logic [31:0]   n1_f;
    logic [QW:0]   n1_int;

    assign w_win = s_axis_tdata[pffd_pkg::USED_W-1:0];

    always_comb begin
        n_csh  = w_win >> n_nbits;
        n_nt   = {w_win[11:1], 5'd0};
        n_nsum = {1'b0, n_nt} + {12'd0, n_nt[15:11]} + 17'd1;
        n_nval = {1'b0, w_win[11:1], 5'd0} + {11'd0, n_nsum[16:11]};

        n1_val    = '0;
        n1_neg    = 1'b0;
        n1_raw    = '0;
        n1_is_raw = 1'b0;
        n1_bits   = 6'd0;
        n1_interp = 1'b0;
        n1_f      = '0;
        n1_int    = '0;

        case (r_mode)
            pffd_pkg::MODE_COORD: begin
                if (w_win[0] | w_win[1]) begin
                    n1_neg = w_win[2];
                end
                if (w_win[0]) begin
                    n1_val = ((QW+1)'(w_win[16:3]) + 49'd1) << 16;
                end
                if (w_win[1]) begin
                    n1_val = n1_val + ((QW+1)'(w_win[0] ? w_win[21:17] : w_win[7:3]) << 11);
                end
                n1_bits = 6'd2 + {5'd0, w_win[0] | w_win[1]} + (w_win[0] ? 6'd14 : 6'd0)
                        + (w_win[1] ? 6'd5 : 6'd0);
            end
            pffd_pkg::MODE_MP_INT: begin
                n1_int = w_win[0] ? (QW+1)'(w_win[13:3]) : (QW+1)'(w_win[16:3]);
                if (w_win[1]) begin
                    n1_neg  = w_win[2];
                    n1_val  = (n1_int + 49'd1) << 16;
                    n1_bits = w_win[0] ? 6'd14 : 6'd17;
                end else begin
                    n1_bits = 6'd2;
                end
            end
            pffd_pkg::MODE_MP, pffd_pkg::MODE_MP_LOW: begin
                n1_int = w_win[0] ? (QW+1)'(w_win[13:3]) : (QW+1)'(w_win[16:3]);
                n1_neg = w_win[2];
                if (w_win[1]) begin
                    n1_val  = (n1_int + 49'd1) << 16;
                    n1_bits = w_win[0] ? 6'd14 : 6'd17;
                end else begin
                    n1_bits = 6'd3;
                end
                if (r_mode == pffd_pkg::MODE_MP) begin
                    n1_val  = n1_val + ((QW+1)'(w_win[1] ? (w_win[0] ? w_win[18:14] : w_win[21:17])
                                                         : w_win[7:3]) << 11);
                    n1_bits = n1_bits + 6'd5;
                end else begin
                    n1_val  = n1_val + ((QW+1)'(w_win[1] ? (w_win[0] ? w_win[16:14] : w_win[19:17])
                                                         : w_win[5:3]) << 13);
                    n1_bits = n1_bits + 6'd3;
                end
            end
            pffd_pkg::MODE_RAW: begin
                n1_raw    = w_win[31:0];
                n1_is_raw = 1'b1;
                n1_bits   = 6'd32;
            end
            pffd_pkg::MODE_NORMAL: begin
                n1_neg  = w_win[0];
                n1_val  = (QW+1)'(n_nval);
                n1_bits = 6'd12;
            end
            pffd_pkg::MODE_CELL, pffd_pkg::MODE_CELL_LOW, pffd_pkg::MODE_CELL_INT: begin
                n1_val = {1'b0, w_win[31:0] & n_mask, 16'd0};
                if (r_mode == pffd_pkg::MODE_CELL) begin
                    n1_val  = n1_val + ((QW+1)'(n_csh[4:0]) << 11);
                    n1_bits = n_nbits + 6'd5;
                end else if (r_mode == pffd_pkg::MODE_CELL_LOW) begin
                    n1_val  = n1_val + ((QW+1)'(n_csh[2:0]) << 13);
                    n1_bits = n_nbits + 6'd3;
                end else begin
                    n1_bits = n_nbits;
                end
            end
            default: begin
                n1_interp = 1'b1;
                n1_f      = w_win[31:0] & n_mask;
                n1_bits   = n_nbits;
            end
        endcase
    end

    logic          r1_vld;
    logic [QW:0]   r1_val;
    logic          r1_neg;
    logic [31:0]   r1_raw;
    logic          r1_is_raw;
    logic [5:0]    r1_bits;
    logic          r1_interp;
    logic [31:0]   r1_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_val    <= n1_val;
            r1_neg    <= n1_neg;
            r1_raw    <= n1_raw;
            r1_is_raw <= n1_is_raw;
            r1_bits   <= n1_bits;
            r1_interp <= n1_interp;
            r1_f      <= n1_f;
        end
    end

    // stage 2: saturate, sign, partial products
    logic [QW-1:0] n2_mag;
    pffd_pkg::t_side n2_side;

    always_comb begin
        n2_mag = (r1_val[QW:QW-1] != 2'b00) ? pffd_pkg::Q_MAX : r1_val[QW-1:0];
        n2_side.val    = r1_neg ? (QW'(0) - n2_mag) : n2_mag;
        n2_side.raw    = r1_raw;
        n2_side.is_raw = r1_is_raw;
        n2_side.bits   = r1_bits;
        n2_side.interp = r1_interp;
    end

    logic            r2_vld;
    pffd_pkg::t_side r2_side;
    logic [55:0]     r2_pl;
    logic [55:0]     r2_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_side <= n2_side;
            r2_pl   <= r_mag[23:0] * r1_f;
            r2_ph   <= r_mag[47:24] * r1_f;
        end
    end

    // stage 3: product sum
    logic            r3_vld;
    pffd_pkg::t_side r3_side;
    logic [pffd_pkg::PROD_W-1:0] r3_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_side <= r2_side;
            r3_prod <= pffd_pkg::PROD_W'(r2_pl) + {r2_ph, 24'd0};
        end
    end

    // divide by 2^n - 1
    logic            w_dv_vld;
    logic [QW-1:0]   w_dv_quot;
    logic            w_dv_rnz;
    pffd_pkg::t_side w_dv_side;

    pffd_div_pipe u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (r3_vld),
        .i_prod   (r3_prod),
        .i_den    (r_den),
        .i_side   (r3_side),
        .o_vld    (w_dv_vld),
        .o_quot   (w_dv_quot),
        .o_rem_nz (w_dv_rnz),
        .o_side   (w_dv_side)
    );

    // interpolation result, truncated toward zero
    logic [QW-1:0] n_base;
    logic [QW-1:0] n_ival;
    logic [OW-1:0] n_out_dat;

    always_comb begin
        n_base = r_dneg ? (r_low - w_dv_quot) : (r_low + w_dv_quot);
        n_ival = n_base;
        if (w_dv_rnz && !r_dneg && n_base[QW-1]) begin
            n_ival = n_base + QW'(1);
        end else if (w_dv_rnz && r_dneg && !n_base[QW-1] && (n_base != '0)) begin
            n_ival = n_base - QW'(1);
        end
        n_out_dat = {2'b00, w_dv_side.bits, w_dv_side.raw,
                     w_dv_side.interp ? n_ival : w_dv_side.val};
    end

    // output register and skid entry
    logic          r_out_vld;
    logic [OW-1:0] r_out_dat;
    logic          r_out_usr;
    logic [OW-1:0] r_skd_dat;
    logic          r_skd_usr;
    logic          w_take;

    assign w_take = r_out_vld & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (r_skd_vld) begin
            if (w_take) begin
                r_skd_vld <= 1'b0;
            end
        end else if (w_dv_vld) begin
            if (!r_out_vld || w_take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skd_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_vld) begin
            if (w_take) begin
                r_out_dat <= r_skd_dat;
                r_out_usr <= r_skd_usr;
            end
        end else if (w_dv_vld) begin
            if (!r_out_vld || w_take) begin
                r_out_dat <= n_out_dat;
                r_out_usr <= w_dv_side.is_raw;
            end else begin
                r_skd_dat <= n_out_dat;
                r_skd_usr <= w_dv_side.is_raw;
            end
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = r_out_dat;
    assign m_axis_tuser[0] = r_out_usr;

    a_skd_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid entry held with empty output register");

    a_raw_val_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[47:0] == '0))
        else $error("raw transaction carries a non-zero value");

    a_raw_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[79:48] == '0))
        else $error("non-raw transaction carries a raw word");

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[85:80] != 6'd0) && (m_axis_tdata[85:80] <= 6'd37)))
        else $error("bits used out of range");

endmodule

/* hdl/pffd_div_pipe.sv */
// Pipelined restoring divider, two quotient bits per stage, with sideband.
module pffd_div_pipe (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [pffd_pkg::PROD_W-1:0] i_prod,
    input  logic [pffd_pkg::DEN_W-1:0]  i_den,
    input  pffd_pkg::t_side             i_side,
    output logic                        o_vld,
    output logic [pffd_pkg::Q_W-1:0]    o_quot,
    output logic                        o_rem_nz,
    output pffd_pkg::t_side             o_side
);

    localparam int NST = pffd_pkg::Q_W / 2;
    localparam int DW  = pffd_pkg::DEN_W;
    localparam int QW  = pffd_pkg::Q_W;

    logic                  r_vld  [NST];
    logic [DW-1:0]         r_rem  [NST];
    logic [QW-1:0]         r_dvd  [NST];
    logic [QW-1:0]         r_quo  [NST];
    pffd_pkg::t_side       r_side [NST];

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [DW:0] f_step(input logic [DW-1:0] rem, input logic b,
                                           input logic [DW-1:0] den);
        logic [DW:0] t;
        logic [DW:0] d;
        begin
            t = {rem, b};
            d = t - {1'b0, den};
            if (t >= {1'b0, den}) begin
                f_step = {1'b1, d[DW-1:0]};
            end else begin
                f_step = {1'b0, t[DW-1:0]};
            end
        end
    endfunction

    for (genvar k = 0; k < NST; k++) begin : g_st
        logic            w_vld;
        logic [DW-1:0]   w_rem;
        logic [QW-1:0]   w_dvd;
        logic [QW-1:0]   w_quo;
        pffd_pkg::t_side w_side;
        logic [DW:0]     w_s0;
        logic [DW:0]     w_s1;

        if (k == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = i_prod[pffd_pkg::PROD_W-1:QW];
            assign w_dvd  = i_prod[QW-1:0];
            assign w_quo  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_dvd  = r_dvd[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_s0 = f_step(w_rem, w_dvd[QW-1], i_den);
        assign w_s1 = f_step(w_s0[DW-1:0], w_dvd[QW-2], i_den);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_s1[DW-1:0];
                r_dvd[k]  <= {w_dvd[QW-3:0], 2'b00};
                r_quo[k]  <= {w_quo[QW-3:0], w_s0[DW], w_s1[DW]};
                r_side[k] <= w_side;
            end
        end
    end

    assign o_vld    = r_vld[NST-1];
    assign o_quot   = r_quo[NST-1];
    assign o_rem_nz = |r_rem[NST-1];
    assign o_side   = r_side[NST-1];

endmodule

/* test/packed_float_field_decoder_test.sv */
// Stream testbench of the packed float field decoder: random windows, APB phases, field checks.
`timescale 1ns / 1ps

module packed_float_field_decoder_test;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [47:0] BOUND_MIN = 48'h8000_0000_0000;
    localparam logic [47:0] BOUND_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_TOP = 64'sh7FFF_FFFF_FFFF;
    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [pffd_pkg::Q_W-1:0]    value;
        logic [pffd_pkg::RAW_W-1:0]  raw;
        logic                        is_raw;
        logic [pffd_pkg::BITS_W-1:0] bits;
    } t_field_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [63:0]            s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [pffd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [4:0]             paddr = '0;
    logic [63:0]            pwdata = '0;
    logic [63:0]            prdata;
    logic                   pready;

    // decoder settings as last written
    logic [3:0]  cfg_mode = pffd_pkg::MODE_INTERP;
    logic [5:0]  cfg_fbits = 6'd8;
    logic [47:0] cfg_low = 48'd0;
    logic [47:0] cfg_high = 48'd65536;

    logic [63:0]   window_q[$];
    t_field_result decoded_q[$];
    int            windows_queued = 0;
    int            windows_taken = 0;
    logic          window_fire = 1'b0;
    int            mismatches = 0;
    int            idle_cycles = 0;
    int            send_gap = 0;
    int            sink_stall = 0;
    logic          steady = 1'b0;
    t_field_result want;

    packed_float_field_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [63:0] bits_at(input logic [63:0] w, input int unsigned pos,
                                            input int unsigned n);
        return (w >> pos) & ((64'd1 << n) - 64'd1);
    endfunction

    function automatic t_field_result decode_window(input logic [63:0] w);
        t_field_result r;
        int unsigned pos, n, fb, ib;
        logic signed [63:0] v, lo_s, hi_s, d, q_s, base;
        logic [63:0] mag, den, f;
        logic [127:0] prod, quo, rem;
        logic neg;
        r = '0;
        v = 0;
        neg = 1'b0;
        pos = 0;
        n = (cfg_fbits == 6'd0) ? 1 : ((cfg_fbits > 6'd32) ? 32 : int'(cfg_fbits));
        case (cfg_mode)
            pffd_pkg::MODE_COORD: begin
                pos = 2;
                if (w[0] || w[1]) begin
                    neg = w[2];
                    pos = 3;
                    if (w[0]) begin
                        v = (bits_at(w, pos, 14) + 64'd1) << 16;
                        pos += 14;
                    end
                    if (w[1]) begin
                        v += bits_at(w, pos, 5) << 11;
                        pos += 5;
                    end
                end
            end
            pffd_pkg::MODE_MP, pffd_pkg::MODE_MP_LOW: begin
                ib = w[0] ? 11 : 14;
                fb = (cfg_mode == pffd_pkg::MODE_MP_LOW) ? 3 : 5;
                neg = w[2];
                pos = 3;
                if (w[1]) begin
                    v = (bits_at(w, pos, ib) + 64'd1) << 16;
                    pos += ib;
                end
                v += bits_at(w, pos, fb) << (16 - fb);
                pos += fb;
            end
            pffd_pkg::MODE_MP_INT: begin
                ib = w[0] ? 11 : 14;
                pos = 2;
                if (w[1]) begin
                    neg = w[2];
                    pos = 3;
                    v = (bits_at(w, pos, ib) + 64'd1) << 16;
                    pos += ib;
                end
            end
            pffd_pkg::MODE_RAW: begin
                r.raw = w[31:0];
                r.is_raw = 1'b1;
                pos = 32;
            end
            pffd_pkg::MODE_NORMAL: begin
                neg = w[0];
                v = (bits_at(w, 1, 11) << 16) / 64'd2047;
                pos = 12;
            end
            pffd_pkg::MODE_CELL, pffd_pkg::MODE_CELL_LOW, pffd_pkg::MODE_CELL_INT: begin
                v = bits_at(w, 0, n) << 16;
                pos = n;
                if (cfg_mode != pffd_pkg::MODE_CELL_INT) begin
                    fb = (cfg_mode == pffd_pkg::MODE_CELL_LOW) ? 3 : 5;
                    v += bits_at(w, pos, fb) << (16 - fb);
                    pos += fb;
                end
                if (v > Q_TOP) v = Q_TOP;
            end
            default: begin
                // interpolation, also for codes above nine
                lo_s = {{16{cfg_low[47]}}, cfg_low};
                hi_s = {{16{cfg_high[47]}}, cfg_high};
                d = hi_s - lo_s;
                mag = (d < 0) ? -d : d;
                f = bits_at(w, 0, n);
                den = (64'd1 << n) - 64'd1;
                prod = {64'd0, mag} * {64'd0, f};
                quo = prod / {64'd0, den};
                rem = prod % {64'd0, den};
                q_s = quo[63:0];
                if (d >= 0) begin
                    base = lo_s + q_s;
                    if (rem != 0 && base < 0) base = base + 1;
                end else begin
                    base = lo_s - q_s;
                    if (rem != 0 && base > 0) base = base - 1;
                end
                v = base;
                pos = n;
            end
        endcase
        if (neg) v = -v;
        r.value = v[47:0];
        r.bits = pos[5:0];
        return r;
    endfunction

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // source side
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !window_fire) begin
                // hold until the transaction completes
            end else if (send_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap--;
            end else if (window_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= window_q.pop_front();
                send_gap = idle_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink side
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (sink_stall != 0) begin
                m_axis_tready <= 1'b0;
                sink_stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) sink_stall = idle_len();
            end
        end
    end

    // monitor, scoreboard and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t unexpected result expected none actual %h %h", $time,
                             m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("value_fixed", 64'(want.value), 64'(m_axis_tdata[47:0]));
                    check_field("raw_word", 64'(want.raw), 64'(m_axis_tdata[79:48]));
                    check_field("bits_used", 64'(want.bits), 64'(m_axis_tdata[85:80]));
                    check_field("is_raw", 64'(want.is_raw), 64'(m_axis_tuser[0]));
                end
            end
            window_fire <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                decoded_q.push_back(decode_window(s_axis_tdata));
                windows_taken <= windows_taken + 1;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("packed_float_field_decoder: mismatch");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            pffd_pkg::REG_MODE:  cfg_mode = val[3:0];
            pffd_pkg::REG_FBITS: cfg_fbits = val[5:0];
            pffd_pkg::REG_LOW:   cfg_low = val[47:0];
            default:             cfg_high = val[47:0];
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (windows_taken != windows_queued || decoded_q.size() != 0);
    endtask

    task automatic set_cfg(input logic [3:0] mode, input logic [5:0] fb,
                           input logic [47:0] lo, input logic [47:0] hi);
        wait_drained();
        apb_write(pffd_pkg::REG_MODE, {60'd0, mode});
        apb_write(pffd_pkg::REG_FBITS, {58'd0, fb});
        apb_write(pffd_pkg::REG_LOW, {{16{lo[47]}}, lo});
        apb_write(pffd_pkg::REG_HIGH, {{16{hi[47]}}, hi});
    endtask

    task automatic queue_window(input logic [63:0] w);
        window_q.push_back(w);
        windows_queued++;
    endtask

    function automatic logic [47:0] rand_bound();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return BOUND_MIN;
            1:       return BOUND_MAX;
            2:       return 48'd0;
            3:       return 48'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return r[47:0];
        endcase
    endfunction

    initial begin
        logic [3:0] mode;
        logic [5:0] fb;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: interpolation over 8 bits, 0 to 1
        queue_window(64'h00);
        queue_window(64'hFF);
        queue_window(64'h80);

        set_cfg(pffd_pkg::MODE_COORD, 6'd8, 48'd0, 48'd0);
        queue_window(64'd0);
        queue_window(ONES);
        queue_window(64'h7);
        queue_window(64'h6);      // sign on zero fraction
        set_cfg(pffd_pkg::MODE_MP, 6'd8, 48'd0, 48'd0);
        queue_window(ONES);
        queue_window(64'hFFFF_FFFE);
        set_cfg(pffd_pkg::MODE_MP_LOW, 6'd8, 48'd0, 48'd0);
        queue_window(ONES);
        set_cfg(pffd_pkg::MODE_MP_INT, 6'd8, 48'd0, 48'd0);
        queue_window(64'h6);
        queue_window(64'h5);
        set_cfg(pffd_pkg::MODE_RAW, 6'd8, 48'd0, 48'd0);
        queue_window(ONES);
        queue_window(64'h8000_0000_0000_0000);
        set_cfg(pffd_pkg::MODE_NORMAL, 6'd8, 48'd0, 48'd0);
        queue_window(ONES);
        queue_window(64'h1);
        queue_window(64'h7E);     // fraction just below one step
        set_cfg(pffd_pkg::MODE_CELL, 6'd32, 48'd0, 48'd0);
        queue_window(ONES);       // saturates
        set_cfg(pffd_pkg::MODE_CELL, 6'd0, 48'd0, 48'd0);
        queue_window(ONES);
        set_cfg(pffd_pkg::MODE_CELL_LOW, 6'd33, 48'd0, 48'd0);
        queue_window(ONES);
        set_cfg(pffd_pkg::MODE_CELL_INT, 6'd63, 48'd0, 48'd0);
        queue_window(ONES);
        set_cfg(pffd_pkg::MODE_INTERP, 6'd32, BOUND_MIN, BOUND_MAX);
        queue_window(ONES);
        queue_window(64'd0);
        queue_window(64'h8000_0001);
        set_cfg(4'hF, 6'd5, BOUND_MAX, BOUND_MIN);
        queue_window(64'h15);

        while (windows_queued < 1225) begin
            mode = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
            case ($urandom_range(0, 5))
                0:       fb = 6'd0;
                1:       fb = 6'd32;
                2:       fb = 6'($urandom_range(33, 63));
                default: fb = 6'($urandom_range(1, 31));
            endcase
            set_cfg(mode, fb, rand_bound(), rand_bound());
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(20, 80)) queue_window({$urandom, $urandom});
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && decoded_q.size() == 0)
            $display("packed_float_field_decoder: match");
        else
            $display("packed_float_field_decoder: mismatch");
        $finish;
    end

endmodule
